// ===== design/dpwp_pkg.sv =====
package dpwp_pkg;

   localparam int IMAGE_WIDTH  = 848;
   localparam int IMAGE_HEIGHT = 480;
   localparam int MARGIN       = 5;
   localparam int STRIDE       = 2;
   localparam int LIMIT_W      = 13;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_MIN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_MAX  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRINCIPAL  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_FOCAL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_X      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_Y      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_Z      = 3'd6;

   localparam logic [15:0] DEPTH_MIN_RESET = 16'd100;
   localparam logic [15:0] DEPTH_MAX_RESET = 16'd3500;

   localparam logic [63:0] CAM_ROUND   = 64'h0000_0000_0008_0000;
   localparam logic [62:0] WORLD_ROUND = 63'h0000_0000_2000_0000;
   localparam logic signed [32:0] WORLD_MAX = 33'sd32767;
   localparam logic signed [32:0] WORLD_MIN = -33'sd32768;

   typedef struct packed {
      logic mul_en;
      logic mag_en;
      logic rnd_en;
   } cam_en_type;

   typedef struct packed {
      logic prod_en;
      logic sum_en;
   } world_en_type;

endpackage

// ===== design/depth_pixel_to_world_point.sv =====
// Kept pixels each give one item at rsp_tvalid; dropped pixels give no item.
// Throughput: one item per cycle; six register stages, each with its own valid bit,
// and a stalled output holds only the full stages between it and the nearest empty stage.
// Reset (synchronous, active high) clears all valid bits and loads the register
// defaults: depth min 100, depth max 3500, all other registers zero.
module depth_pixel_to_world_point (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pixel_col[9:0], pixel_row[18:10], depth_raw[34:19]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // world_x_mm[15:0], world_y_mm[31:16], world_z_mm[47:32]
   output logic [1:0]  rsp_tuser,   // depth_clamped[0], coord_saturated[1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [15:0] depth_min_ff, depth_max_ff;
   logic [31:0] pp_ff;
   logic [63:0] invf_ff, row_x_ff, row_y_ff, row_z_ff;

   logic [6:1] vld_ff, vld_in, adv;

   logic [9:0]  pix_col;
   logic [8:0]  pix_row;
   logic [15:0] pix_depth;
   logic        col_ok, row_ok, keep;

   logic signed [17:0] dqx_ff, dqx_in, dqy_ff, dqy_in;
   logic [15:0]        d1_ff, d1_in, d2_ff, d3_ff;
   logic [6:1]         clamp_ff;
   logic               clamp_in;
   logic signed [44:0] cam_x, cam_y, camz_ff, camz_in;
   logic signed [15:0] wx, wy, wz;
   logic               sx, sy, sz;

   dpwp_pkg::cam_en_type   cam_en;
   dpwp_pkg::world_en_type world_en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_min_ff <= dpwp_pkg::DEPTH_MIN_RESET;
         depth_max_ff <= dpwp_pkg::DEPTH_MAX_RESET;
         pp_ff        <= '0;
         invf_ff      <= '0;
         row_x_ff     <= '0;
         row_y_ff     <= '0;
         row_z_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            dpwp_pkg::CSR_DEPTH_MIN: depth_min_ff <= csr_data[15:0];
            dpwp_pkg::CSR_DEPTH_MAX: depth_max_ff <= csr_data[15:0];
            dpwp_pkg::CSR_PRINCIPAL: pp_ff        <= csr_data[31:0];
            dpwp_pkg::CSR_INV_FOCAL: invf_ff      <= csr_data;
            dpwp_pkg::CSR_ROW_X:     row_x_ff     <= csr_data;
            dpwp_pkg::CSR_ROW_Y:     row_y_ff     <= csr_data;
            dpwp_pkg::CSR_ROW_Z:     row_z_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // a stage advances when it is empty or the next one advances
   always_comb begin
      adv[6] = !vld_ff[6] || rsp_tready;
      adv[5] = !vld_ff[5] || adv[6];
      adv[4] = !vld_ff[4] || adv[5];
      adv[3] = !vld_ff[3] || adv[4];
      adv[2] = !vld_ff[2] || adv[3];
      adv[1] = !vld_ff[1] || adv[2];
   end

   assign req_tready = adv[1];

   always_comb begin
      pix_col   = req_tdata[9:0];
      pix_row   = req_tdata[18:10];
      pix_depth = req_tdata[34:19];
      col_ok = (pix_col >= 10'(dpwp_pkg::MARGIN))
            && ({3'b0, pix_col} < dpwp_pkg::LIMIT_W'(dpwp_pkg::IMAGE_WIDTH - dpwp_pkg::MARGIN))
            && ((10'(pix_col - 10'(dpwp_pkg::MARGIN)) & 10'(dpwp_pkg::STRIDE - 1)) == '0);
      row_ok = (pix_row >= 9'(dpwp_pkg::MARGIN))
            && ({4'b0, pix_row} < dpwp_pkg::LIMIT_W'(dpwp_pkg::IMAGE_HEIGHT - dpwp_pkg::MARGIN))
            && ((9'(pix_row - 9'(dpwp_pkg::MARGIN)) & 9'(dpwp_pkg::STRIDE - 1)) == '0);
      keep     = col_ok && row_ok && (pix_depth != '0) && (pix_depth >= depth_min_ff);
      clamp_in = pix_depth > depth_max_ff;
      d1_in    = clamp_in ? depth_max_ff : pix_depth;
      dqx_in   = $signed({4'b0, pix_col, 4'b0}) - $signed({2'b0, pp_ff[15:0]});
      dqy_in   = $signed({5'b0, pix_row, 4'b0}) - $signed({2'b0, pp_ff[31:16]});
      camz_in  = $signed({13'b0, d3_ff, 16'b0});

      vld_in[1] = adv[1] ? (req_tvalid && keep) : vld_ff[1];
      for (int k = 2; k <= 6; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         dqx_ff      <= dqx_in;
         dqy_ff      <= dqy_in;
         d1_ff       <= d1_in;
         clamp_ff[1] <= clamp_in;
      end
      if (adv[2]) begin
         d2_ff       <= d1_ff;
         clamp_ff[2] <= clamp_ff[1];
      end
      if (adv[3]) begin
         d3_ff       <= d2_ff;
         clamp_ff[3] <= clamp_ff[2];
      end
      if (adv[4]) begin
         camz_ff     <= camz_in;
         clamp_ff[4] <= clamp_ff[3];
      end
      if (adv[5]) begin
         clamp_ff[5] <= clamp_ff[4];
      end
      if (adv[6]) begin
         clamp_ff[6] <= clamp_ff[5];
      end
   end

   assign cam_en.mul_en   = adv[2];
   assign cam_en.mag_en   = adv[3];
   assign cam_en.rnd_en   = adv[4];
   assign world_en.prod_en = adv[5];
   assign world_en.sum_en  = adv[6];

   dpwp_cam_axis u_cam_x (
      .clock     (clock),
      .en        (cam_en),
      .offset_q4 (dqx_ff),
      .depth     (d1_ff),
      .inv_focal (invf_ff[31:0]),
      .cam       (cam_x)
   );

   dpwp_cam_axis u_cam_y (
      .clock     (clock),
      .en        (cam_en),
      .offset_q4 (dqy_ff),
      .depth     (d1_ff),
      .inv_focal (invf_ff[63:32]),
      .cam       (cam_y)
   );

   dpwp_world_axis u_world_x (
      .clock (clock),
      .en    (world_en),
      .row   (row_x_ff),
      .cam_x (cam_x),
      .cam_y (cam_y),
      .cam_z (camz_ff),
      .world (wx),
      .sat   (sx)
   );

   dpwp_world_axis u_world_y (
      .clock (clock),
      .en    (world_en),
      .row   (row_y_ff),
      .cam_x (cam_x),
      .cam_y (cam_y),
      .cam_z (camz_ff),
      .world (wy),
      .sat   (sy)
   );

   dpwp_world_axis u_world_z (
      .clock (clock),
      .en    (world_en),
      .row   (row_z_ff),
      .cam_x (cam_x),
      .cam_y (cam_y),
      .cam_z (camz_ff),
      .world (wz),
      .sat   (sz)
   );

   assign rsp_tvalid = vld_ff[6];
   assign rsp_tdata  = {wz, wy, wx};
   assign rsp_tuser  = {sx || sy || sz, clamp_ff[6]};

   a_zero_depth_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata[34:19] == 16'd0)) |=> !vld_ff[1])
      else $error("zero-depth pixel entered the pipeline");

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_tready) |-> !req_tready)
      else $error("input taken while every stage is full and stalled");

   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[1] && clamp_ff[1]) |-> (d1_ff == depth_max_ff))
      else $error("clamped depth differs from the maximum");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      (vld_ff == '0) |-> req_tready)
      else $error("empty pipeline refuses input");

endmodule

// ===== design/dpwp_cam_axis.sv =====
module dpwp_cam_axis (
   input  logic                     clock,
   input  dpwp_pkg::cam_en_type     en,
   input  logic signed [17:0]       offset_q4,
   input  logic [15:0]              depth,
   input  logic [31:0]              inv_focal,
   output logic signed [44:0]       cam
);

   logic signed [32:0] t_ff, t_in;
   logic               neg_ff, neg_in;
   logic [63:0]        prod_ff, prod_in;
   logic signed [44:0] cam_ff, cam_in;
   logic signed [34:0] t_full;
   logic [32:0]        t_abs;
   logic [63:0]        rounded;
   logic [43:0]        mag_r;

   always_comb begin
      t_full  = offset_q4 * $signed({1'b0, depth});
      t_in    = 33'(t_full);
      neg_in  = t_ff[32];
      t_abs   = neg_in ? 33'(-t_ff) : t_ff;
      prod_in = t_abs[31:0] * inv_focal;
      // magnitude rounded half away from zero
      rounded = prod_ff + dpwp_pkg::CAM_ROUND;
      mag_r   = rounded[63:20];
      cam_in  = neg_ff ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
   end

   always_ff @(posedge clock) begin
      if (en.mul_en) begin
         t_ff <= t_in;
      end
      if (en.mag_en) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
      end
      if (en.rnd_en) begin
         cam_ff <= cam_in;
      end
   end

   assign cam = cam_ff;

endmodule

// ===== design/dpwp_world_axis.sv =====
module dpwp_world_axis (
   input  logic                     clock,
   input  dpwp_pkg::world_en_type   en,
   input  logic [63:0]              row,
   input  logic signed [44:0]       cam_x,
   input  logic signed [44:0]       cam_y,
   input  logic signed [44:0]       cam_z,
   output logic signed [15:0]       world,
   output logic                     sat
);

   logic signed [60:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic signed [62:0] trans_sh;
   logic signed [62:0] sum;
   logic signed [32:0] w_full;
   logic signed [15:0] world_ff, world_in;
   logic               sat_ff, sat_in;

   always_comb begin
      p0_in    = $signed(row[15:0])  * cam_x;
      p1_in    = $signed(row[31:16]) * cam_y;
      p2_in    = $signed(row[47:32]) * cam_z;
      trans_sh = $signed({{17{row[63]}}, row[63:48], 30'b0});
      // round half toward +inf, then floor shift
      sum      = p0_ff + p1_ff + p2_ff + trans_sh + $signed(dpwp_pkg::WORLD_ROUND);
      w_full   = sum[62:30];
      if (w_full > dpwp_pkg::WORLD_MAX) begin
         world_in = 16'sh7FFF;
         sat_in   = 1'b1;
      end else if (w_full < dpwp_pkg::WORLD_MIN) begin
         world_in = -16'sh8000;
         sat_in   = 1'b1;
      end else begin
         world_in = w_full[15:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.prod_en) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (en.sum_en) begin
         world_ff <= world_in;
         sat_ff   <= sat_in;
      end
   end

   assign world = world_ff;
   assign sat   = sat_ff;

endmodule

// ===== dv/depth_pixel_to_world_point_tb.sv =====
module depth_pixel_to_world_point_tb;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      logic        clamped;
      logic        saturated;
   } world_point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [dpwp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   depth_pixel_to_world_point dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // register shadow
   logic [15:0] cfg_depth_min = dpwp_pkg::DEPTH_MIN_RESET;
   logic [15:0] cfg_depth_max = dpwp_pkg::DEPTH_MAX_RESET;
   logic [31:0] cfg_principal = '0;
   logic [63:0] cfg_inv_focal = '0;
   logic [63:0] cfg_rows [3] = '{64'd0, 64'd0, 64'd0};

   world_point_type pending_points [$];
   int pixels_sent = 0;
   int pixels_dropped = 0;
   int points_checked = 0;
   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   function automatic bit on_sample_grid(input int p, input int size);
      if (p < dpwp_pkg::MARGIN || p + dpwp_pkg::MARGIN >= size) return 1'b0;
      return ((p - dpwp_pkg::MARGIN) % dpwp_pkg::STRIDE) == 0;
   endfunction

   // offset (Q.4 px) * depth * inverse focal (Q0.32) -> Q.16 mm, half away from zero
   function automatic longint backproject_axis(input longint offset, input logic [15:0] depth,
                                               input logic [31:0] inv_q32);
      longint prod;
      longint unsigned mag, hi, lo, r;
      prod = offset * longint'(depth);
      if (prod < 0) mag = -prod;
      else mag = prod;
      hi = mag * longint'(inv_q32[31:16]);
      lo = mag * longint'(inv_q32[15:0]);
      r = (hi + ((lo + 64'h80000) >> 16)) >> 4;
      if (prod < 0) return -longint'(r);
      return longint'(r);
   endfunction

   function automatic logic [15:0] transform_axis(input logic [63:0] coeffs,
         input longint cam_x, input longint cam_y, input longint cam_z, inout bit sat);
      longint acc;
      acc = longint'($signed(coeffs[15:0])) * cam_x
          + longint'($signed(coeffs[31:16])) * cam_y
          + longint'($signed(coeffs[47:32])) * cam_z;
      acc = acc + (longint'($signed(coeffs[63:48])) <<< 30) + (longint'(1) <<< 29);
      acc = acc >>> 30;
      if (acc > 32767) begin
         acc = 32767;
         sat = 1'b1;
      end else if (acc < -32768) begin
         acc = -32768;
         sat = 1'b1;
      end
      return acc[15:0];
   endfunction

   function automatic bit project_pixel(input logic [9:0] col, input logic [8:0] row,
                                        input logic [15:0] depth_in, output world_point_type pt);
      logic [15:0] d;
      longint cam_x, cam_y, cam_z;
      bit sat;
      pt = '0;
      sat = 1'b0;
      if (!on_sample_grid(col, dpwp_pkg::IMAGE_WIDTH) ||
          !on_sample_grid(row, dpwp_pkg::IMAGE_HEIGHT))
         return 1'b0;
      if (depth_in == 0 || depth_in < cfg_depth_min) return 1'b0;
      d = depth_in;
      if (d > cfg_depth_max) begin
         d = cfg_depth_max;
         pt.clamped = 1'b1;
      end
      cam_x = backproject_axis((longint'(col) <<< 4) - longint'(cfg_principal[15:0]), d,
                               cfg_inv_focal[31:0]);
      cam_y = backproject_axis((longint'(row) <<< 4) - longint'(cfg_principal[31:16]), d,
                               cfg_inv_focal[63:32]);
      cam_z = longint'(d) <<< 16;
      pt.x = transform_axis(cfg_rows[0], cam_x, cam_y, cam_z, sat);
      pt.y = transform_axis(cfg_rows[1], cam_x, cam_y, cam_z, sat);
      pt.z = transform_axis(cfg_rows[2], cam_x, cam_y, cam_z, sat);
      pt.saturated = sat;
      return 1'b1;
   endfunction

   function automatic logic [63:0] make_row(input int r0, input int r1, input int r2,
                                            input int t);
      return {t[15:0], r2[15:0], r1[15:0], r0[15:0]};
   endfunction

   function automatic logic [63:0] random_rigid_row();
      return make_row(int'($urandom_range(0, 32768)) - 16384,
                      int'($urandom_range(0, 32768)) - 16384,
                      int'($urandom_range(0, 32768)) - 16384,
                      int'($urandom_range(0, 4000)) - 2000);
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
   endtask

   task automatic compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) report_mismatch(what, $signed(want), $signed(got));
   endtask

   always @(posedge clock) begin : check_points
      world_point_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_points.size() == 0) begin
               report_mismatch("unexpected point, tdata", 0, rsp_tdata);
            end else begin
               want = pending_points.pop_front();
               points_checked++;
               compare_field("world_x_mm", want.x, rsp_tdata[15:0]);
               compare_field("world_y_mm", want.y, rsp_tdata[31:16]);
               compare_field("world_z_mm", want.z, rsp_tdata[47:32]);
               compare_field("depth_clamped", {15'd0, want.clamped}, {15'd0, rsp_tuser[0]});
               compare_field("coord_saturated", {15'd0, want.saturated},
                             {15'd0, rsp_tuser[1]});
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic send_pixel(input logic [9:0] col, input logic [8:0] row,
                             input logic [15:0] depth, output bit kept);
      world_point_type pt;
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, depth, row, col};
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      kept = project_pixel(col, row, depth, pt);
      if (kept) pending_points.insert(pending_points.size(), pt);
      else pixels_dropped++;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // drain: dropped pixels never enter the pipeline; wait for every expected point, then idle on to catch stray ones
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_register(input logic [dpwp_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         dpwp_pkg::CSR_DEPTH_MIN: cfg_depth_min = value[15:0];
         dpwp_pkg::CSR_DEPTH_MAX: cfg_depth_max = value[15:0];
         dpwp_pkg::CSR_PRINCIPAL: cfg_principal = value[31:0];
         dpwp_pkg::CSR_INV_FOCAL: cfg_inv_focal = value;
         dpwp_pkg::CSR_ROW_X:     cfg_rows[0] = value;
         dpwp_pkg::CSR_ROW_Y:     cfg_rows[1] = value;
         dpwp_pkg::CSR_ROW_Z:     cfg_rows[2] = value;
         default: ;
      endcase
   endtask

   task automatic program_registers(input logic [15:0] dmin, input logic [15:0] dmax,
         input logic [31:0] pp, input logic [63:0] invf, input logic [63:0] rx,
         input logic [63:0] ry, input logic [63:0] rz);
      write_register(dpwp_pkg::CSR_DEPTH_MIN, {48'd0, dmin});
      write_register(dpwp_pkg::CSR_DEPTH_MAX, {48'd0, dmax});
      write_register(dpwp_pkg::CSR_PRINCIPAL, {32'd0, pp});
      write_register(dpwp_pkg::CSR_INV_FOCAL, invf);
      write_register(dpwp_pkg::CSR_ROW_X, rx);
      write_register(dpwp_pkg::CSR_ROW_Y, ry);
      write_register(dpwp_pkg::CSR_ROW_Z, rz);
      csr_valid <= 1'b0;
   endtask

   task automatic program_camera();
      program_registers(16'd150, 16'd4000, {16'd3831, 16'd6796},
                        {32'd10123191, 32'd10111525},
                        make_row(16384, 0, 0, 100), make_row(0, 16384, 0, -200),
                        make_row(0, 0, 16384, 300));
   endtask

   task automatic random_pixel(output logic [9:0] col, output logic [8:0] row,
                               output logic [15:0] depth);
      int pick;
      if ($urandom_range(0, 99) < 75) begin
         col = 10'(dpwp_pkg::MARGIN + dpwp_pkg::STRIDE * $urandom_range(0, 418));
         row = 9'(dpwp_pkg::MARGIN + dpwp_pkg::STRIDE * $urandom_range(0, 234));
         pick = $urandom_range(0, 99);
         if (pick < 60)
            depth = 16'($urandom_range((cfg_depth_min == 0) ? 1 : cfg_depth_min,
                                       cfg_depth_max));
         else if (pick < 80)
            depth = 16'($urandom_range(cfg_depth_max, 65535));
         else
            depth = 16'($urandom_range(0, 65535));
      end else begin
         col = 10'($urandom_range(0, dpwp_pkg::IMAGE_WIDTH - 1));
         row = 9'($urandom_range(0, dpwp_pkg::IMAGE_HEIGHT - 1));
         depth = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
      end
   endtask

   // all registers at reset values: every kept pixel lands on the origin
   task automatic test_reset_defaults();
      bit hit;
      send_pixel(10'd5, 9'd5, 16'd100, hit);
      send_pixel(10'd842, 9'd474, 16'd3501, hit);
      send_pixel(10'd842, 9'd5, 16'd65535, hit);
      send_pixel(10'd0, 9'd0, 16'd500, hit);
      send_pixel(10'd847, 9'd479, 16'd500, hit);
      send_pixel(10'd5, 9'd5, 16'd99, hit);
      settle();
   endtask

   task automatic test_border_and_grid();
      bit hit;
      program_camera();
      send_pixel(10'd4, 9'd5, 16'd1000, hit);
      send_pixel(10'd5, 9'd4, 16'd1000, hit);
      send_pixel(10'd6, 9'd5, 16'd1000, hit);
      send_pixel(10'd5, 9'd6, 16'd1000, hit);
      send_pixel(10'd843, 9'd5, 16'd1000, hit);
      send_pixel(10'd5, 9'd475, 16'd1000, hit);
      send_pixel(10'd841, 9'd473, 16'd0, hit);
      send_pixel(10'd841, 9'd473, 16'd4000, hit);
      settle();
   endtask

   task automatic test_depth_window();
      bit hit;
      program_registers(16'd0, 16'd65535, cfg_principal, cfg_inv_focal,
                        cfg_rows[0], cfg_rows[1], cfg_rows[2]);
      send_pixel(10'd7, 9'd9, 16'd0, hit);
      send_pixel(10'd7, 9'd9, 16'd1, hit);
      send_pixel(10'd425, 9'd239, 16'd65535, hit);
      settle();
      program_registers(16'd65535, 16'd0, cfg_principal, cfg_inv_focal,
                        cfg_rows[0], cfg_rows[1], cfg_rows[2]);
      send_pixel(10'd425, 9'd239, 16'd65534, hit);
      send_pixel(10'd425, 9'd239, 16'd65535, hit);
      settle();
      // maximum below minimum: min test on raw depth, then clamp
      program_registers(16'd2000, 16'd1000, cfg_principal, cfg_inv_focal,
                        cfg_rows[0], cfg_rows[1], cfg_rows[2]);
      send_pixel(10'd425, 9'd239, 16'd1500, hit);
      send_pixel(10'd425, 9'd239, 16'd2500, hit);
      settle();
   endtask

   task automatic test_coordinate_saturation();
      bit hit;
      program_registers(16'd1, 16'd65535, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                        make_row(32767, 32767, 32767, 32767),
                        make_row(-32768, -32768, -32768, -32768),
                        make_row(0, 0, 0, -32768));
      send_pixel(10'd5, 9'd5, 16'd65535, hit);
      send_pixel(10'd841, 9'd473, 16'd65535, hit);
      send_pixel(10'd5, 9'd5, 16'd1, hit);
      settle();
   endtask

   task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                     input int count);
      bit hit;
      logic [9:0] col;
      logic [8:0] row;
      logic [15:0] depth;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         random_pixel(col, row, depth);
         send_pixel(col, row, depth, hit);
      end
      settle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_border_and_grid();
      test_depth_window();
      test_coordinate_saturation();

      program_camera();
      test_random_stream(0, 0, 332);

      program_registers(16'($urandom_range(1, 500)), 16'($urandom_range(1000, 8000)),
                        {16'($urandom_range(3000, 4600)), 16'($urandom_range(6000, 7600))},
                        {32'($urandom_range(8000000, 12000000)),
                         32'($urandom_range(8000000, 12000000))},
                        random_rigid_row(), random_rigid_row(), random_rigid_row());
      test_random_stream(46, 0, 332);

      program_registers(16'd0, 16'd65535, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                        {$urandom(), $urandom()}, {$urandom(), $urandom()},
                        {$urandom(), $urandom()});
      test_random_stream(0, 46, 332);

      program_registers(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 65535)),
                        $urandom(), {$urandom(), $urandom()}, {$urandom(), $urandom()},
                        {$urandom(), $urandom()}, {$urandom(), $urandom()});
      test_random_stream(27, 27, 332);

      if (pending_points.size() != 0) begin
         mismatch_count += pending_points.size();
         $display("%0d expected points never arrived", pending_points.size());
      end
      $display("Ran %0d pixels (%0d dropped) under reset, camera, extreme and random settings",
               pixels_sent, pixels_dropped);
      $display("Checked %0d world points with sender gaps and receiver stalls mixed in",
               points_checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Timeout with %0d points outstanding", pending_points.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
